[rtl/core/look_disk_scheduler_macros.svh]
// Assertion helpers for the scheduler RTL.
`ifndef LOOK_DISK_SCHEDULER_MACROS_SVH
`define LOOK_DISK_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LDS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lds_pkg.sv]
package lds_pkg;

  localparam int TRACK_W = 16;
  localparam int SEEK_W  = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_START_HEAD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_UP   = 1'd1;

  // Command broadcast to every cell of the chain in the same cycle.
  typedef struct packed {
    logic               ins;
    logic               main_shl;
    logic               aux_push;
    logic               aux_pop;
    logic [TRACK_W-1:0] track;
  } cell_cmd_t;

endpackage

[rtl/core/look_disk_scheduler.sv]
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+--------------------------------------------
// in_       | input     | in_valid / in_stall  | request_track, is_last
// out_      | output    | out_valid / out_stall| served_track, seek_so_far, end_of_schedule,
//           |           |                      | overflowed
// cfg_      | input     | cfg_wr_en            | cfg_index, cfg_data
//
// Each accepted request is inserted into the sorted cell row while the row has
// room. After the last request, the block moves each track on the low side of
// the head (tracks below the head, or at or below it when sweeping down) into
// the reverse row, then finds the end of that side and emits one result per
// cycle while the output is not stalled. The input stalls until the final
// result is emitted; the next batch may start right after that.
// Reset (rst_n low, synchronous) empties both rows and clears the configuration and sequencer registers.
// A stalled output holds its result; the sweep simply waits for it.
`include "look_disk_scheduler_macros.svh"

module look_disk_scheduler #(
  parameter int MAX_REQUESTS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lds_pkg::TRACK_W-1:0]    in_request_track,
  input  logic                           in_is_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lds_pkg::TRACK_W-1:0]    out_served_track,
  output logic [lds_pkg::SEEK_W-1:0]     out_seek_so_far,
  output logic                           out_end_of_schedule,
  output logic                           out_overflowed,
  input  logic                           cfg_wr_en,
  input  logic [lds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lds_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lds_pkg::*;

  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

  // Sequencer states: loading requests, splitting off the low side, sweeping.
  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_SPLIT = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   main_cnt_r, main_cnt_nxt;
  logic [CNT_W-1:0]   aux_cnt_r, aux_cnt_nxt;
  logic [TRACK_W-1:0] start_head_r, start_head_nxt;
  logic               sweep_up_r, sweep_up_nxt;
  logic [TRACK_W-1:0] head_r, head_nxt;
  logic               dir_up_r, dir_up_nxt;
  logic [TRACK_W-1:0] cur_head_r, cur_head_nxt;
  logic [SEEK_W-1:0]  seek_r, seek_nxt;
  logic               ovf_r, ovf_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [TRACK_W-1:0] out_track_r, out_track_nxt;
  logic [SEEK_W-1:0]  out_seek_r, out_seek_nxt;
  logic               out_end_r, out_end_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  logic [TRACK_W-1:0] main_q [MAX_REQUESTS];
  logic [TRACK_W-1:0] aux_q  [MAX_REQUESTS];
  logic               gt_q   [MAX_REQUESTS];

  cell_cmd_t          cmd;
  logic               in_acc;
  logic               full;
  logic               low0;
  logic               split_xfer;
  logic               emit;
  logic               src_aux;
  logic [TRACK_W-1:0] emit_trk;
  logic [TRACK_W-1:0] step_dist;
  logic [SEEK_W-1:0]  seek_sum;
  logic               last_one;
  logic               rows_busy;
  logic               aux_front_low;

  // Input transactions are taken only while the batch is loading.
  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (main_cnt_r == CNT_W'(MAX_REQUESTS));

  // The lowest sorted track belongs to the low side if it lies below the
  // head (sweeping up) or at or below it (sweeping down).
  assign low0 = dir_up_r ? (main_q[0] < head_r) : (main_q[0] <= head_r);
  assign split_xfer = (state_r == ST_SPLIT) && (main_cnt_r != '0) && low0;

  // The reverse row holds the low side in descending order. Sweeping down
  // serves it first; sweeping up serves the ascending high side first.
  assign src_aux  = dir_up_r ? (main_cnt_r == '0) : (aux_cnt_r != '0);
  assign emit_trk = src_aux ? aux_q[0] : main_q[0];
  assign emit     = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign last_one = ({1'b0, main_cnt_r} + {1'b0, aux_cnt_r}) == (CNT_W + 1)'(1);

  assign step_dist = (emit_trk > cur_head_r) ? (emit_trk - cur_head_r)
                                             : (cur_head_r - emit_trk);
  assign seek_sum  = seek_r + {1'b0, step_dist};

  assign rows_busy     = (main_cnt_r != '0) || (aux_cnt_r != '0);
  assign aux_front_low = (aux_cnt_r == '0) ||
                         (dir_up_r ? (aux_q[0] < head_r) : (aux_q[0] <= head_r));

  always_comb begin
    cmd.ins      = in_acc && !full;
    cmd.main_shl = split_xfer || (emit && !src_aux);
    cmd.aux_push = split_xfer;
    cmd.aux_pop  = emit && src_aux;
    cmd.track    = in_request_track;
  end

  // The cell row: each cell compares with the incoming track and takes its
  // left neighbor's value when the new track lands below it.
  for (genvar gi = 0; gi < MAX_REQUESTS; gi++) begin : g_cell
    logic [TRACK_W-1:0] lm, rm, la, ra;
    logic               lg;

    if (gi == 0) begin : g_first
      assign lm = '0;
      assign lg = 1'b0;
      assign la = main_q[0];
    end else begin : g_mid
      assign lm = main_q[gi-1];
      assign lg = gt_q[gi-1];
      assign la = aux_q[gi-1];
    end

    if (gi == MAX_REQUESTS - 1) begin : g_last
      assign rm = '0;
      assign ra = '0;
    end else begin : g_inner
      assign rm = main_q[gi+1];
      assign ra = aux_q[gi+1];
    end

    lds_cell #(
      .IDX   (gi),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .main_cnt   (main_cnt_r),
      .left_main  (lm),
      .left_gt    (lg),
      .right_main (rm),
      .left_aux   (la),
      .right_aux  (ra),
      .main_q     (main_q[gi]),
      .aux_q      (aux_q[gi]),
      .gt         (gt_q[gi])
    );
  end

  // Configuration writes.
  always_comb begin
    start_head_nxt = start_head_r;
    sweep_up_nxt   = sweep_up_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_START_HEAD: start_head_nxt = cfg_data[TRACK_W-1:0];
        REG_SWEEP_UP:   sweep_up_nxt   = cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer and row bookkeeping.
  always_comb begin
    state_nxt    = state_r;
    main_cnt_nxt = main_cnt_r;
    aux_cnt_nxt  = aux_cnt_r;
    head_nxt     = head_r;
    dir_up_nxt   = dir_up_r;
    cur_head_nxt = cur_head_r;
    seek_nxt     = seek_r;
    ovf_nxt      = ovf_r;

    if (cmd.ins) begin
      main_cnt_nxt = main_cnt_r + CNT_W'(1);
    end else if (cmd.main_shl) begin
      main_cnt_nxt = main_cnt_r - CNT_W'(1);
    end
    if (cmd.aux_push) begin
      aux_cnt_nxt = aux_cnt_r + CNT_W'(1);
    end else if (cmd.aux_pop) begin
      aux_cnt_nxt = aux_cnt_r - CNT_W'(1);
    end

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end
          if (in_is_last) begin
            // The registers are sampled as the final request arrives.
            head_nxt     = start_head_r;
            dir_up_nxt   = sweep_up_r;
            cur_head_nxt = start_head_r;
            seek_nxt     = '0;
            state_nxt    = ST_SPLIT;
          end
        end
      end
      ST_SPLIT: begin
        if (!split_xfer) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          cur_head_nxt = emit_trk;
          seek_nxt     = seek_sum;
          if (last_one) begin
            seek_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Output register: it is loaded on each served track and holds under stall.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_track_nxt = out_track_r;
    out_seek_nxt  = out_seek_r;
    out_end_nxt   = out_end_r;
    out_ovf_nxt   = out_ovf_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_track_nxt = emit_trk;
      out_seek_nxt  = seek_sum;
      out_end_nxt   = last_one;
      out_ovf_nxt   = ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      main_cnt_r   <= '0;
      aux_cnt_r    <= '0;
      start_head_r <= '0;
      sweep_up_r   <= 1'b0;
      head_r       <= '0;
      dir_up_r     <= 1'b0;
      cur_head_r   <= '0;
      seek_r       <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      main_cnt_r   <= main_cnt_nxt;
      aux_cnt_r    <= aux_cnt_nxt;
      start_head_r <= start_head_nxt;
      sweep_up_r   <= sweep_up_nxt;
      head_r       <= head_nxt;
      dir_up_r     <= dir_up_nxt;
      cur_head_r   <= cur_head_nxt;
      seek_r       <= seek_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_track_r <= out_track_nxt;
    out_seek_r  <= out_seek_nxt;
    out_end_r   <= out_end_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_served_track    = out_track_r;
  assign out_seek_so_far     = out_seek_r;
  assign out_end_of_schedule = out_end_r;
  assign out_overflowed      = out_ovf_r;

  // The sweep never runs with both rows empty.
  `LDS_ASSERT_IMPL(a_emit_nonempty, state_r == ST_EMIT, rows_busy, "sweep with empty rows")
  // The reverse row is drained by the end of every schedule.
  `LDS_ASSERT_IMPL(a_aux_empty_load, state_r == ST_LOAD, aux_cnt_r == '0, "row not drained")
  // The front of the reverse row is always a low-side track while splitting.
  `LDS_ASSERT_IMPL(a_aux_low, state_r == ST_SPLIT, aux_front_low, "high track in reverse row")
  // Serving the final track returns the block to loading with empty rows.
  `LDS_ASSERT_NEXT(a_end_to_load, emit && last_one, state_r == ST_LOAD && !rows_busy, "not closed")

endmodule

[rtl/core/lds_cell.sv]
module lds_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  logic                        clk,
  input  lds_pkg::cell_cmd_t          cmd,
  input  logic [CNT_W-1:0]            main_cnt,
  input  logic [lds_pkg::TRACK_W-1:0] left_main,
  input  logic                        left_gt,
  input  logic [lds_pkg::TRACK_W-1:0] right_main,
  input  logic [lds_pkg::TRACK_W-1:0] left_aux,
  input  logic [lds_pkg::TRACK_W-1:0] right_aux,
  output logic [lds_pkg::TRACK_W-1:0] main_q,
  output logic [lds_pkg::TRACK_W-1:0] aux_q,
  output logic                        gt
);
  import lds_pkg::*;

  logic [TRACK_W-1:0] main_r, main_nxt;
  logic [TRACK_W-1:0] aux_r, aux_nxt;
  logic               occ;

  // A cell is occupied when it lies below the fill count of the sorted row.
  assign occ = CNT_W'(IDX) < main_cnt;
  assign gt  = occ && (main_r > cmd.track);

  always_comb begin
    main_nxt = main_r;
    if (cmd.ins) begin
      if (occ && !gt) begin
        main_nxt = main_r;
      end else if (left_gt) begin
        main_nxt = left_main;
      end else begin
        main_nxt = cmd.track;
      end
    end else if (cmd.main_shl) begin
      main_nxt = right_main;
    end
  end

  always_comb begin
    aux_nxt = aux_r;
    if (cmd.aux_push) begin
      aux_nxt = left_aux;
    end else if (cmd.aux_pop) begin
      aux_nxt = right_aux;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    aux_r  <= aux_nxt;
  end

  assign main_q = main_r;
  assign aux_q  = aux_r;

endmodule

[dv/tb_look_disk_scheduler.sv]
// Testbench for the LOOK disk scheduler.
//
// Requests are loaded one transaction at a time. The transaction marked last
// starts the sweep, which returns one transaction per stored request. A
// predictor in this module keeps its own sorted copy of the batch and its own
// copy of the two registers. When a last request is accepted, the predictor
// works out the whole schedule and appends it to a queue of expected results.
// Every result the block hands over is compared, field by field, with the
// oldest entry in that queue.
//
// The run has a directed table first and random batches after it. The random
// part has three idling phases: a sender that idles a little with a receiver
// that stalls a lot, then the reverse, then no idling at all. In the last
// phase the receiver holds off for a long stretch while the sender offers a
// batch past capacity, so the block fills up and drops the excess as overflow.
module tb_look_disk_scheduler;
  import lds_pkg::*;

  localparam int MAX_REQ = 32;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [TRACK_W-1:0] track;
    logic [SEEK_W-1:0]  seek;
    logic               eos;
    logic               ovf;
  } sched_result_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  // One row of the directed table. A register row writes value to reg_idx.
  // A request row sends value as the track. Where typed is set, the final
  // result of that batch is the one given here rather than the predicted one.
  typedef struct packed {
    row_kind_t          kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [15:0]        value;
    logic               last;
    logic               typed;
    sched_result_t      result;
  } stim_row_t;

  localparam sched_result_t NO_RESULT = '0;
  localparam int DIR_ROWS = 29;

  // At reset the head sits on track 0 and the sweep goes down. The first rows
  // hit the track extremes with single-request batches, whose results can be
  // read off directly. Two-request batches then reach the largest seek that
  // the track range allows. The batches without typed results cover
  // duplicates, tracks equal to the head and both sweep directions.
  stim_row_t directed_rows [DIR_ROWS] = '{
    '{ROW_ITEM, REG_START_HEAD, 16'h0000, 1'b1, 1'b1, '{16'h0000, 17'd0, 1'b1, 1'b0}},
    '{ROW_ITEM, REG_START_HEAD, 16'hFFFF, 1'b1, 1'b1, '{16'hFFFF, 17'd65535, 1'b1, 1'b0}},
    '{ROW_CFG,  REG_START_HEAD, 16'hFFFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_START_HEAD, 16'h0000, 1'b1, 1'b1, '{16'h0000, 17'd65535, 1'b1, 1'b0}},
    '{ROW_ITEM, REG_START_HEAD, 16'hFFFF, 1'b1, 1'b1, '{16'hFFFF, 17'd0, 1'b1, 1'b0}},
    '{ROW_CFG,  REG_SWEEP_UP,   16'h0001, 1'b0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_START_HEAD, 16'h0000, 1'b1, 1'b1, '{16'h0000, 17'd65535, 1'b1, 1'b0}},
    '{ROW_ITEM, REG_START_HEAD, 16'hFFFF, 1'b1, 1'b1, '{16'hFFFF, 17'd0, 1'b1, 1'b0}},
    '{ROW_CFG,  REG_START_HEAD, 16'h0001, 1'b0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_START_HEAD, 16'hFFFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_START_HEAD, 16'h0000, 1'b1, 1'b1, '{16'h0000, 17'd131069, 1'b1, 1'b0}},
    '{ROW_CFG,  REG_START_HEAD, 16'h8000, 1'b0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_START_HEAD, 16'h8000, 1'b0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_START_HEAD, 16'h7FFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_START_HEAD, 16'hFFFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_START_HEAD, 16'h8000, 1'b0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_START_HEAD, 16'h0001, 1'b0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_START_HEAD, 16'h8001, 1'b1, 1'b0, NO_RESULT},
    '{ROW_CFG,  REG_SWEEP_UP,   16'h0000, 1'b0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_START_HEAD, 16'hAAAA, 1'b0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_START_HEAD, 16'h5555, 1'b0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_START_HEAD, 16'h8000, 1'b0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_START_HEAD, 16'h7FFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_START_HEAD, 16'h8000, 1'b1, 1'b0, NO_RESULT},
    '{ROW_CFG,  REG_START_HEAD, 16'h1234, 1'b0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_START_HEAD, 16'h1234, 1'b1, 1'b1, '{16'h1234, 17'd0, 1'b1, 1'b0}},
    '{ROW_CFG,  REG_START_HEAD, 16'hFFFE, 1'b0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_START_HEAD, 16'h0000, 1'b0, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_START_HEAD, 16'hFFFF, 1'b1, 1'b1, '{16'hFFFF, 17'd131069, 1'b1, 1'b0}}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [TRACK_W-1:0]    in_request_track;
  logic                  in_is_last;
  logic                  out_valid;
  logic                  out_stall;
  logic [TRACK_W-1:0]    out_served_track;
  logic [SEEK_W-1:0]     out_seek_so_far;
  logic                  out_end_of_schedule;
  logic                  out_overflowed;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state: the batch loaded so far, kept in ascending order with
  // equal tracks in arrival order, and the register values last written.
  logic [TRACK_W-1:0] sorted_tracks [$];
  logic               overflow_seen = 1'b0;
  logic [TRACK_W-1:0] start_head_q = '0;
  logic               sweep_up_q = 1'b0;
  sched_result_t      pending_results [$];

  int   error_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   stall_left = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   quiet_cycles = 0;
  logic [TRACK_W-1:0] prev_pick = '0;

  look_disk_scheduler #(
    .MAX_REQUESTS(MAX_REQ)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_request_track   (in_request_track),
    .in_is_last         (in_is_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_served_track   (out_served_track),
    .out_seek_so_far    (out_seek_so_far),
    .out_end_of_schedule(out_end_of_schedule),
    .out_overflowed     (out_overflowed),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #1 clk = ~clk;

  // Records one accepted request. A request beyond capacity is dropped and
  // marks the batch as overflowed. When the request is the last one, the
  // whole LOOK sweep is worked out from the configured head and appended to
  // the expected results. The batch is then cleared.
  function automatic void take_request(input logic [TRACK_W-1:0] track,
                                       input logic last, input logic typed,
                                       input sched_result_t typed_res);
    int                 pos;
    int                 i;
    logic [TRACK_W-1:0] head;
    logic [TRACK_W-1:0] step_dist;
    logic [SEEK_W-1:0]  seek;
    logic [TRACK_W-1:0] sweep [$];
    sched_result_t      res;

    if (sorted_tracks.size() >= MAX_REQ) begin
      overflow_seen = 1'b1;
    end else begin
      pos = sorted_tracks.size();
      while (pos > 0 && sorted_tracks[pos-1] > track) pos--;
      sorted_tracks.insert(pos, track);
    end
    if (!last) return;

    head = start_head_q;
    if (!sweep_up_q) begin
      for (i = sorted_tracks.size() - 1; i >= 0; i--)
        if (sorted_tracks[i] <= head) sweep.push_back(sorted_tracks[i]);
      for (i = 0; i < sorted_tracks.size(); i++)
        if (sorted_tracks[i] > head) sweep.push_back(sorted_tracks[i]);
    end else begin
      for (i = 0; i < sorted_tracks.size(); i++)
        if (sorted_tracks[i] >= head) sweep.push_back(sorted_tracks[i]);
      for (i = sorted_tracks.size() - 1; i >= 0; i--)
        if (sorted_tracks[i] < head) sweep.push_back(sorted_tracks[i]);
    end

    seek = '0;
    for (i = 0; i < sweep.size(); i++) begin
      step_dist = (sweep[i] > head) ? sweep[i] - head : head - sweep[i];
      seek = seek + SEEK_W'(step_dist);
      head = sweep[i];
      res.track = sweep[i];
      res.seek  = seek;
      res.eos   = (i == sweep.size() - 1);
      res.ovf   = overflow_seen;
      pending_results.push_back(res);
    end
    if (typed && sweep.size() > 0) pending_results[pending_results.size()-1] = typed_res;

    sorted_tracks.delete();
    overflow_seen = 1'b0;
  endfunction

  // Tracks are drawn so that the head itself, its neighbors, the range ends
  // and repeats of the previous track all come up often.
  function automatic logic [TRACK_W-1:0] pick_track();
    logic [TRACK_W-1:0] t;

    case ($urandom_range(0, 9))
      0: t = start_head_q;
      1: t = start_head_q + 1'b1;
      2: t = start_head_q - 1'b1;
      3: t = '0;
      4: t = '1;
      5: t = prev_pick;
      default: t = TRACK_W'($urandom);
    endcase
    prev_pick = t;
    return t;
  endfunction

  // Offers one request and waits until it is taken. The sender may idle for
  // some cycles first; once valid is raised, the payload holds until accepted.
  task automatic send_item(input logic [TRACK_W-1:0] track, input logic last,
                           input logic typed, input sched_result_t typed_res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_request_track <= track;
    in_is_last       <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    take_request(track, last, typed, typed_res);
  endtask

  // Drops valid and waits until every expected result has arrived, plus a
  // few cycles, so that the block is surely idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes one register. The enable is lowered on a later edge so that
  // back-to-back writes never assign it twice in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_START_HEAD: start_head_q = value;
      REG_SWEEP_UP:   sweep_up_q = value[0];
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Picks a new head, with the range ends weighted up, and a new direction.
  task automatic program_random_config();
    logic [15:0] head;

    case ($urandom_range(0, 3))
      0: head = '0;
      1: head = '1;
      default: head = 16'($urandom);
    endcase
    write_reg(REG_START_HEAD, head);
    write_reg(REG_SWEEP_UP, 16'($urandom_range(0, 1)));
  endtask

  task automatic note_mismatch(input string what, input sched_result_t want,
                               input sched_result_t got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected track %0d seek %0d end %0b ovf %0b",
               $realtime, what, want.track, want.seek, want.eos, want.ovf);
      $display("%0t: %s: got      track %0d seek %0d end %0b ovf %0b",
               $realtime, what, got.track, got.seek, got.eos, got.ovf);
    end
  endtask

  // Receiver side. It stalls at random at the phase's rate, except for one
  // long hold-off that the stimulus asks for once, counted here.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall  <= 1'b1;
      stall_left <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Result checker: each accepted transaction is matched against the oldest
  // expected result.
  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;

    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{out_served_track, out_seek_so_far, out_end_of_schedule, out_overflowed};
      if (pending_results.size() == 0) begin
        note_mismatch("result with none expected", NO_RESULT, got);
      end else begin
        want = pending_results.pop_front();
        if (got.track !== want.track || got.seek !== want.seek ||
            got.eos !== want.eos || got.ovf !== want.ovf)
          note_mismatch("result mismatch", want, got);
      end
    end
  end

  // Watchdog: any long stretch without a transaction or a register write
  // means the block has hung.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
          cfg_wr_en)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int  phase;
    int  phase_items;
    int  batch_len;
    int  k;
    bit  first_batch;
    bit  skip_cfg;

    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_request_track = '0;
    in_is_last       = 1'b0;
    out_stall        = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Register rows wait for the block to drain first.
    send_idle_pct = 10;
    recv_idle_pct = 10;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed_rows[r].reg_idx, directed_rows[r].value);
      end else begin
        send_item(directed_rows[r].value, directed_rows[r].last,
                  directed_rows[r].typed, directed_rows[r].result);
      end
    end

    // Random batches in three idling phases. Most batches are short; the
    // last phase opens with a batch past capacity under a long receiver hold.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 22; recv_idle_pct = 57; end
        1: begin send_idle_pct = 57; recv_idle_pct = 22; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      phase_items = 0;
      first_batch = 1'b1;
      skip_cfg    = 1'b0;
      while (phase_items < 20) begin
        if (first_batch || (!skip_cfg && $urandom_range(0, 2) == 0)) begin
          wait_idle();
          program_random_config();
        end
        skip_cfg = 1'b0;
        batch_len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20)
                                                : $urandom_range(1, 8);
        if (phase == 2 && first_batch) begin
          // The receiver holds off while this batch, past capacity, is offered,
          // so the block fills up and marks the batch as overflowed.
          hold_req <= 1'b1;
          batch_len = $urandom_range(MAX_REQ + 2, MAX_REQ + 5);
          skip_cfg  = 1'b1;
        end
        for (k = 0; k < batch_len; k++)
          send_item(pick_track(), k == batch_len - 1, 1'b0, NO_RESULT);
        phase_items += batch_len;
        first_batch = 1'b0;
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    error_count += pending_results.size();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
